/* rtl/core/fpfa_pkg.sv */
`timescale 1ns / 1ps

package fpfa_pkg;

  localparam int SIZE_W   = 16;
  localparam int FREE_W   = 20;
  localparam int TOTAL_W  = 24;
  localparam int OPC_W    = 2;
  localparam int SLOT_IN_W = 4;
  localparam int MODE_W   = 2;
  localparam int COUNT_W  = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PART_COUNT = 1'b1;

  typedef enum logic [OPC_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_ALLOC   = 2'd1,
    OP_RESTART = 2'd2,
    OP_NOP     = 2'd3
  } opcode_t;

  typedef enum logic [MODE_W-1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
  } status_t;

endpackage

/* rtl/core/fpfa_ctrl.sv */
`timescale 1ns / 1ps

module fpfa_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [fpfa_pkg::OPC_W-1:0]      opcode,
  input  fpfa_pkg::status_t               status,
  output fpfa_pkg::cmd_t                  cmd,
  output logic                            busy
);
  import fpfa_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   needs_scan;

  assign needs_scan = (opcode_t'(opcode) == OP_ALLOC) || (opcode_t'(opcode) == OP_RESTART);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = needs_scan ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_DONE: begin
        cmd.commit = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/core/fpfa_datapath.sv */
`timescale 1ns / 1ps

module fpfa_datapath #(
  parameter int MAX_PARTITIONS = 16,
  localparam int SLOT_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1,
  localparam int CNT_W  = $clog2(MAX_PARTITIONS + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fpfa_pkg::cmd_t                      cmd,
  output fpfa_pkg::status_t                   status,
  input  logic [fpfa_pkg::OPC_W-1:0]          opcode,
  input  logic [fpfa_pkg::SLOT_IN_W-1:0]      slot_index,
  input  logic [fpfa_pkg::SIZE_W-1:0]         size_value,
  input  logic [fpfa_pkg::MODE_W-1:0]         fit_mode,
  input  logic [CNT_W-1:0]                    n_active,
  output logic                                out_strobe,
  output logic                                out_granted,
  output logic [fpfa_pkg::SLOT_IN_W-1:0]      out_partition_slot,
  output logic [fpfa_pkg::SIZE_W-1:0]         out_granted_size,
  output logic [fpfa_pkg::SIZE_W-1:0]         out_internal_fragment,
  output logic                                out_external_flag,
  output logic [fpfa_pkg::TOTAL_W-1:0]        out_total_internal,
  output logic [fpfa_pkg::TOTAL_W-1:0]        out_total_external,
  output logic [fpfa_pkg::FREE_W-1:0]         out_free_memory
);
  import fpfa_pkg::*;

  logic [SIZE_W-1:0]         mem_r [MAX_PARTITIONS];
  logic [MAX_PARTITIONS-1:0] marks_r;

  opcode_t             op_r;
  logic [SIZE_W-1:0]   req_r;
  logic [CNT_W-1:0]    k_r;
  logic                rd_valid_r;
  logic [SLOT_W-1:0]   rd_idx_r;
  logic [SIZE_W-1:0]   rd_data_r;
  logic                have_r;
  logic [SLOT_W-1:0]   pick_idx_r;
  logic [SIZE_W-1:0]   pick_sz_r;
  logic [FREE_W-1:0]   free_r;
  logic [TOTAL_W-1:0]  int_total_r;
  logic [TOTAL_W-1:0]  ext_total_r;

  logic                strobe_r;
  logic                granted_r;
  logic [SLOT_IN_W-1:0] slot_out_r;
  logic [SIZE_W-1:0]   gsize_r;
  logic [SIZE_W-1:0]   frag_r;
  logic                ext_r;

  opcode_t             op_in;
  logic                issue;
  logic                load_ok;
  logic                cand_free;
  logic                fits;
  logic                take;
  logic                grant;
  logic                ext_hit;
  logic [SIZE_W-1:0]   frag;
  logic [FREE_W:0]     free_sum;
  logic [FREE_W-1:0]   free_acc_nxt;
  logic [FREE_W-1:0]   free_sub_nxt;
  logic [TOTAL_W:0]    int_sum;
  logic [TOTAL_W-1:0]  int_total_nxt;
  logic [TOTAL_W:0]    ext_sum;
  logic [TOTAL_W-1:0]  ext_total_nxt;

  assign op_in   = opcode_t'(opcode);
  assign load_ok = 32'(slot_index) < MAX_PARTITIONS;
  assign issue   = cmd.scan && (k_r != n_active);
  assign status.scan_done = (k_r == n_active) && !rd_valid_r;

  assign cand_free = !marks_r[rd_idx_r];
  assign fits      = rd_data_r >= req_r;

  always_comb begin
    case (fit_mode_t'(fit_mode))
      FIT_WORST: take = cand_free && (!have_r || (rd_data_r > pick_sz_r));
      FIT_BEST:  take = cand_free && fits && (!have_r || (rd_data_r < pick_sz_r));
      default:   take = cand_free && fits && !have_r;
    endcase
  end

  assign grant   = have_r && (pick_sz_r >= req_r);
  assign ext_hit = free_r >= FREE_W'(req_r);
  assign frag    = pick_sz_r - req_r;

  assign free_sum      = {1'b0, free_r} + (FREE_W + 1)'(rd_data_r);
  assign free_acc_nxt  = free_sum[FREE_W] ? '1 : free_sum[FREE_W-1:0];
  assign free_sub_nxt  = (free_r > FREE_W'(pick_sz_r)) ? free_r - FREE_W'(pick_sz_r) : '0;
  assign int_sum       = {1'b0, int_total_r} + (TOTAL_W + 1)'(frag);
  assign int_total_nxt = int_sum[TOTAL_W] ? '1 : int_sum[TOTAL_W-1:0];
  assign ext_sum       = {1'b0, ext_total_r} + (TOTAL_W + 1)'(req_r);
  assign ext_total_nxt = ext_sum[TOTAL_W] ? '1 : ext_sum[TOTAL_W-1:0];

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marks_r     <= '0;
      free_r      <= '0;
      int_total_r <= '0;
      ext_total_r <= '0;
      k_r         <= '0;
      rd_valid_r  <= 1'b0;
      have_r      <= 1'b0;
      strobe_r    <= 1'b0;
    end else begin
      strobe_r <= cmd.commit;
      if (cmd.accept) begin
        k_r        <= '0;
        rd_valid_r <= 1'b0;
        have_r     <= 1'b0;
        if (op_in == OP_RESTART) begin
          marks_r     <= '0;
          free_r      <= '0;
          int_total_r <= '0;
          ext_total_r <= '0;
        end
      end
      if (cmd.scan) begin
        rd_valid_r <= issue;
        if (issue) begin
          k_r <= k_r + 1'b1;
        end
        if (rd_valid_r) begin
          if (op_r == OP_RESTART) begin
            free_r <= free_acc_nxt;
          end else if (take) begin
            have_r <= 1'b1;
          end
        end
      end
      if (cmd.commit && (op_r == OP_ALLOC)) begin
        if (grant) begin
          marks_r[pick_idx_r] <= 1'b1;
          free_r              <= free_sub_nxt;
          int_total_r         <= int_total_nxt;
        end else if (ext_hit) begin
          ext_total_r <= ext_total_nxt;
        end
      end
    end
  end

  // payload and size table
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= op_in;
      req_r <= size_value;
      if ((op_in == OP_LOAD) && load_ok) begin
        mem_r[SLOT_W'(slot_index)] <= size_value;
      end
    end
    if (issue) begin
      rd_data_r <= mem_r[k_r[SLOT_W-1:0]];
      rd_idx_r  <= k_r[SLOT_W-1:0];
    end
    if (cmd.scan && rd_valid_r && (op_r != OP_RESTART) && take) begin
      pick_idx_r <= rd_idx_r;
      pick_sz_r  <= rd_data_r;
    end
    if (cmd.commit) begin
      granted_r  <= (op_r == OP_ALLOC) && grant;
      slot_out_r <= ((op_r == OP_ALLOC) && grant) ? SLOT_IN_W'(pick_idx_r) : '0;
      gsize_r    <= ((op_r == OP_ALLOC) && grant) ? pick_sz_r : '0;
      frag_r     <= ((op_r == OP_ALLOC) && grant) ? frag : '0;
      ext_r      <= (op_r == OP_ALLOC) && !grant && ext_hit;
    end
  end

  assign out_strobe            = strobe_r;
  assign out_granted           = granted_r;
  assign out_partition_slot    = slot_out_r;
  assign out_granted_size      = gsize_r;
  assign out_internal_fragment = frag_r;
  assign out_external_flag     = ext_r;
  assign out_total_internal    = int_total_r;
  assign out_total_external    = ext_total_r;
  assign out_free_memory       = free_r;

`ifndef SYNTHESIS
  a_grant_excl_ext: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> !(granted_r && ext_r))
    else $error("grant and external flag together");

  a_frag_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && granted_r) |->
      ((SIZE_W + 1)'(gsize_r) == (SIZE_W + 1)'(req_r) + (SIZE_W + 1)'(frag_r)))
    else $error("fragment does not match granted size");

  a_mark_set: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && (op_r == OP_ALLOC) && grant) |=> marks_r[$past(pick_idx_r)])
    else $error("granted partition not marked");

  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid_r |-> (CNT_W'(rd_idx_r) < n_active))
    else $error("scan read beyond active slots");
`endif

endmodule

/* rtl/core/fixed_partition_fit_allocator.sv */
`timescale 1ns / 1ps

// Fixed-partition allocator with first, best and worst fit.
// Input: an item is taken when start is high and busy is low. in_opcode
// selects load (writes in_size_value to slot in_slot_index), allocate
// (request of in_size_value), restart (clears marks and totals, sums the
// active partition sizes into free memory) or no-op.
// Config: cfg_we writes cfg_wdata to register cfg_index (0 fit mode,
// 1 partition count) in the same edge; write only while idle.
// Output: every item gives one result, shown for one cycle with out_strobe.
// The receiver cannot stall; a result not taken in that cycle is lost.
// Flow: load and no-op skip the scan and go straight to the result.
// Allocate and restart scan the N active slots one per cycle through the
// size table's registered read port, N being the active partition count
// (at most MAX_PARTITIONS). A new item can be accepted in the cycle the
// strobe is shown.
// Reset: fit mode, count, marks, totals and free memory clear to zero;
// the size table holds unknown contents until loaded.

module fixed_partition_fit_allocator #(
  parameter int MAX_PARTITIONS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [fpfa_pkg::OPC_W-1:0]          in_opcode,
  input  logic [fpfa_pkg::SLOT_IN_W-1:0]      in_slot_index,
  input  logic [fpfa_pkg::SIZE_W-1:0]         in_size_value,
  input  logic                                cfg_we,
  input  logic [fpfa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fpfa_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                                out_strobe,
  output logic                                out_granted,
  output logic [fpfa_pkg::SLOT_IN_W-1:0]      out_partition_slot,
  output logic [fpfa_pkg::SIZE_W-1:0]         out_granted_size,
  output logic [fpfa_pkg::SIZE_W-1:0]         out_internal_fragment,
  output logic                                out_external_flag,
  output logic [fpfa_pkg::TOTAL_W-1:0]        out_total_internal,
  output logic [fpfa_pkg::TOTAL_W-1:0]        out_total_external,
  output logic [fpfa_pkg::FREE_W-1:0]         out_free_memory
);
  import fpfa_pkg::*;

  localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);

  logic [MODE_W-1:0]  fit_mode_r;
  logic [COUNT_W-1:0] part_count_r;
  logic [CNT_W-1:0]   n_active;
  cmd_t               cmd;
  status_t            status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r   <= '0;
      part_count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIT_MODE:   fit_mode_r   <= cfg_wdata[MODE_W-1:0];
        CFG_PART_COUNT: part_count_r <= cfg_wdata[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // counts above the table depth saturate
  assign n_active = (32'(part_count_r) > MAX_PARTITIONS) ? CNT_W'(MAX_PARTITIONS)
                                                         : CNT_W'(part_count_r);

  fpfa_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .opcode (in_opcode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  fpfa_datapath #(
    .MAX_PARTITIONS (MAX_PARTITIONS)
  ) u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .status                (status),
    .opcode                (in_opcode),
    .slot_index            (in_slot_index),
    .size_value            (in_size_value),
    .fit_mode              (fit_mode_r),
    .n_active              (n_active),
    .out_strobe            (out_strobe),
    .out_granted           (out_granted),
    .out_partition_slot    (out_partition_slot),
    .out_granted_size      (out_granted_size),
    .out_internal_fragment (out_internal_fragment),
    .out_external_flag     (out_external_flag),
    .out_total_internal    (out_total_internal),
    .out_total_external    (out_total_external),
    .out_free_memory       (out_free_memory)
  );

endmodule
